// ===== sv/aes_pkg.sv =====
// AES block encryption package: sizes, item types and round functions.
// No dependencies; used by aes_front, aes_engine and the top level.
`timescale 1ns / 1ps

package aes_pkg;

    localparam int ROUND_COUNT_DEF = 10;
    localparam int ROUND_COUNT_MAX = 14;
    localparam int BLOCK_W = 128;
    localparam int SLOT_W = 4;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic {
        OP_KEY_LOAD = 1'b0,
        OP_ENCRYPT  = 1'b1
    } opcode_t;

    // Item passed from the front end to the round engine
    typedef struct packed {
        opcode_t              op;
        logic [SLOT_W-1:0]    slot;
        logic [BLOCK_W-1:0]   data;
    } item_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_FETCH = 2'd1,
        ST_ROUND = 2'd2,
        ST_OUT   = 2'd3
    } eng_state_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte i of the block sits in bits 127-8i .. 120-8i
    function automatic logic [7:0] get_byte(input logic [BLOCK_W-1:0] s, input int i);
        return s[BLOCK_W-1-8*i -: 8];
    endfunction

    // SubBytes, ShiftRows and optionally MixColumns of one round
    function automatic logic [BLOCK_W-1:0] round_fn(input logic [BLOCK_W-1:0] s,
                                                    input logic mix);
        logic [7:0] t [16];
        logic [7:0] all;
        logic [BLOCK_W-1:0] r;
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) begin
                t[k + 4*c] = sbox(get_byte(s, k + 4*((c + k) & 3)));
            end
        end
        for (int c = 0; c < 4; c++) begin
            all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
            for (int k = 0; k < 4; k++) begin
                r[BLOCK_W-1-8*(k+4*c) -: 8] = mix
                    ? (t[4*c+k] ^ all ^ xtime(t[4*c+k] ^ t[4*c+((k+1)&3)]))
                    : t[4*c+k];
            end
        end
        return r;
    endfunction

endpackage

// ===== sv/aes_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module aes_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 11
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/aes_front.sv =====
// Front end: accepts transactions, drops out-of-range key loads, queues items.
// Depends on aes_pkg.
`timescale 1ns / 1ps

module aes_front #(
    parameter int ROUND_COUNT = aes_pkg::ROUND_COUNT_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  aes_pkg::item_t  in_item,
    output logic            q_valid,
    input  logic            q_ready,
    output aes_pkg::item_t  q_item
);

    localparam int D = aes_pkg::QUEUE_DEPTH;

    aes_pkg::item_t   buf_reg [D];
    logic             wp_reg, rp_reg;
    logic [1:0]       cnt_reg;
    logic             push, pop, keep;

    // Key loads beyond the last slot are consumed without effect
    assign keep = (in_item.op == aes_pkg::OP_ENCRYPT) ||
                  ({1'b0, in_item.slot} <= 5'(ROUND_COUNT));
    assign in_ready = (cnt_reg != 2'(D));
    assign push = in_valid && in_ready && keep;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop = q_valid && q_ready;
    assign q_item = buf_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wp_reg] <= in_item;
        end
    end

    // Queue pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// ===== sv/aes_engine.sv =====
// Round engine: key store writes and iterative encryption, one round a cycle.
// Depends on aes_pkg and aes_ram.
`timescale 1ns / 1ps

module aes_engine #(
    parameter int ROUND_COUNT = aes_pkg::ROUND_COUNT_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_valid,
    output logic                         q_ready,
    input  aes_pkg::item_t               q_item,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [aes_pkg::BLOCK_W-1:0]  out_data
);

    localparam int DEPTH = ROUND_COUNT + 1;
    localparam int AW = $clog2(DEPTH);

    aes_pkg::eng_state_t state_reg, state_next;
    logic [AW-1:0]  rnd_reg, rnd_next;
    logic [aes_pkg::BLOCK_W-1:0] st_reg, st_next, key;
    logic [aes_pkg::BLOCK_W-1:0] res_reg;
    logic res_valid_reg;
    logic take, we, start;
    logic [AW-1:0] raddr;

    assign take = q_valid && q_ready;
    assign we = take && (q_item.op == aes_pkg::OP_KEY_LOAD);
    assign start = take && (q_item.op == aes_pkg::OP_ENCRYPT);

    aes_ram #(.WIDTH(aes_pkg::BLOCK_W), .DEPTH(DEPTH)) u_keys (
        .aclk  (aclk),
        .we    (we),
        .waddr (q_item.slot[AW-1:0]),
        .wdata (q_item.data),
        .raddr (raddr),
        .rdata (key)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            aes_pkg::ST_IDLE:  if (start) state_next = aes_pkg::ST_FETCH;
            aes_pkg::ST_FETCH: state_next = aes_pkg::ST_ROUND;
            aes_pkg::ST_ROUND:
                if (rnd_reg == AW'(ROUND_COUNT)) state_next = aes_pkg::ST_OUT;
            aes_pkg::ST_OUT:   if (out_ready) state_next = aes_pkg::ST_IDLE;
            default:           state_next = aes_pkg::ST_IDLE;
        endcase
    end

    // Datapath control: the round key for the next round is read ahead
    always_comb begin
        q_ready = 1'b0;
        rnd_next = rnd_reg;
        st_next = st_reg;
        raddr = rnd_reg;
        case (state_reg)
            aes_pkg::ST_IDLE: begin
                q_ready = 1'b1;
                rnd_next = '0;
                st_next = q_item.data;
                raddr = '0;
            end
            aes_pkg::ST_FETCH: begin
                // key 0 available now; fetch key 1
                st_next = st_reg ^ key;
                rnd_next = AW'(1);
                raddr = AW'(1);
            end
            aes_pkg::ST_ROUND: begin
                st_next = aes_pkg::round_fn(st_reg, rnd_reg != AW'(ROUND_COUNT)) ^ key;
                rnd_next = rnd_reg + AW'(1);
                // no read ahead past the last round key
                raddr = (rnd_reg == AW'(ROUND_COUNT)) ? rnd_reg : rnd_reg + AW'(1);
            end
            default: ;
        endcase
    end

    // FETCH waits for key 0 from the registered RAM read; ROUND state uses key read last cycle.
    // In IDLE raddr=0 so FETCH sees key 0; in FETCH raddr=1 so round 1 sees key 1.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= aes_pkg::ST_IDLE;
            rnd_reg <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            rnd_reg <= rnd_next;
            if (state_reg == aes_pkg::ST_ROUND && rnd_reg == AW'(ROUND_COUNT)) begin
                res_valid_reg <= 1'b1;
            end else if (out_ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        st_reg <= st_next;
        if (state_reg == aes_pkg::ST_ROUND && rnd_reg == AW'(ROUND_COUNT)) begin
            res_reg <= st_next;
        end
    end

    assign out_valid = res_valid_reg;
    assign out_data = res_reg;

endmodule

// ===== sv/aes128_block_encrypt_top.sv =====
// AES-128 block encryption (FIPS-197) with a loadable round-key store of
// ROUND_COUNT+1 entries. A key-load transaction (opcode 0) writes one entry and
// returns nothing; an encrypt transaction (opcode 1) returns one ciphertext.
// An encryption occupies the round engine from the key fetch through the initial
// AddRoundKey and the rounds, one round per cycle through a single shared round
// unit and key RAM port, until the result is handed off. A key load is written
// as it leaves the queue. A two-entry queue decouples input from the engine.
// Depends on aes_pkg, aes_front, aes_engine, aes_ram.
`timescale 1ns / 1ps

module aes128_block_encrypt_top #(
    parameter int ROUND_COUNT = aes_pkg::ROUND_COUNT_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,   // key_slot[3:0], word_hi[67:4], word_lo[131:68], zero
    input  logic         s_tuser,   // opcode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata    // cipher_hi[63:0], cipher_lo[127:64]
);

    aes_pkg::item_t in_item, q_item;
    logic q_valid, q_ready;
    logic [aes_pkg::BLOCK_W-1:0] res;

    assign in_item.op = aes_pkg::opcode_t'(s_tuser);
    assign in_item.slot = s_tdata[3:0];
    assign in_item.data = {s_tdata[67:4], s_tdata[131:68]};

    aes_front #(.ROUND_COUNT(ROUND_COUNT)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_item(in_item),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    aes_engine #(.ROUND_COUNT(ROUND_COUNT)) u_engine (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_data(res)
    );

    assign m_tdata = {res[63:0], res[127:64]};

endmodule

// ===== sv/aes_checker.sv =====
// Port-level checker for the AES block, bound to the top level.
// Depends on aes128_block_encrypt_top ports only.
`timescale 1ns / 1ps

module aes_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata
);

    // No result straight out of reset
    a_no_out_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid) else $error("result valid after reset");

    // A stalled result keeps its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed under stall");

    // A valid result carries known data
    a_known: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !$isunknown(m_tdata))
        else $error("unknown result data");

    // Input is ready again out of reset
    a_ready_reset: assert property (@(posedge aclk)
        !aresetn |=> s_tready) else $error("not ready after reset");

endmodule

bind aes128_block_encrypt_top aes_checker u_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
